// ----- src/bse_pkg.sv -----
// Shared types and constants for the bubble sort engine.
// No dependencies; imported by every module of the block but bse_checker.
`default_nettype none

package bse_pkg;

  localparam int DATA_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_SORT  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } bse_state_t;

endpackage : bse_pkg

`default_nettype wire

// ----- src/bse_mem.sv -----
// Element store: one write port, one read port, registered read data.
// Depends on bse_pkg for the data width.
`default_nettype none

module bse_mem
  import bse_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0]      rd_data_r
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

endmodule : bse_mem

`default_nettype wire

// ----- src/bse_seq.sv -----
// Sequencer and compare/swap datapath: load, bubble passes, read-out.
// Depends on bse_pkg; drives the ports of bse_mem.
`default_nettype none

module bse_seq
  import bse_pkg::*;
#(
  parameter int CAPACITY = 8,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last,
  output logic                          busy,
  output logic                          out_valid_r,
  output logic                          out_final_r,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic signed [DATA_W-1:0]      mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  wire logic signed [DATA_W-1:0] mem_rdata
);

  bse_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [ADDR_W-1:0]        pend_idx_r, pend_idx_nxt;
  logic signed [DATA_W-1:0] carry_r, carry_nxt;
  logic                     swap_r, swap_nxt;
  logic                     out_valid_nxt, out_final_nxt;
  logic [ADDR_W-1:0]        last_idx;
  logic                     accept;
  logic                     full;

  assign last_idx = ADDR_W'(cnt_r - CNT_W'(1));
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign busy     = (state_r != ST_LOAD) || out_valid_r;
  assign accept   = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = idx_r;
    carry_nxt     = carry_r;
    swap_nxt      = swap_r;
    out_valid_nxt = 1'b0;
    out_final_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[ADDR_W-1:0];
    mem_wdata     = in_value;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;

    // Pass datapath: the larger value rides along in carry_r; the smaller
    // one of each pair is written back one slot below the slot just read.
    if (pend_r) begin
      if (pend_idx_r == '0) begin
        carry_nxt = mem_rdata;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = pend_idx_r - ADDR_W'(1);
        if (carry_r > mem_rdata) begin
          mem_wdata = mem_rdata;
          swap_nxt  = 1'b1;
        end else begin
          mem_wdata = carry_r;
          carry_nxt = mem_rdata;
        end
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[ADDR_W-1:0];
            mem_wdata = in_value;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_last) begin
            state_nxt = ST_SORT;
            idx_nxt   = '0;
            swap_nxt  = 1'b0;
          end
        end
      end
      ST_SORT: begin
        mem_re       = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
        if (idx_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        // Park the pass maximum in the top slot.
        mem_we    = 1'b1;
        mem_waddr = last_idx;
        mem_wdata = carry_r;
        idx_nxt   = '0;
        swap_nxt  = 1'b0;
        state_nxt = swap_r ? ST_SORT : ST_EMIT;
      end
      ST_EMIT: begin
        mem_re        = 1'b1;
        out_valid_nxt = 1'b1;
        out_final_nxt = (idx_r == last_idx);
        if (idx_r == last_idx) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      swap_r      <= swap_nxt;
      out_valid_r <= out_valid_nxt;
      out_final_r <= out_final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    carry_r    <= carry_nxt;
  end

endmodule : bse_seq

`default_nettype wire

// ----- src/bubble_sort_engine.sv -----
// Bubble sort engine: loads a set of signed values one beat at a time until a beat
// with in_last, sorts it in place with early-exit bubble passes, then streams it
// out in ascending order with out_final_res on the final beat. A beat is taken
// when start is high and busy is low; beats past CAPACITY are dropped, but one
// carrying in_last still closes the set. With n stored values, each pass reads
// the store once per slot, one read of the store per cycle, then spends a drain
// state and writes the pass maximum to the top slot; up to n passes run before
// one makes no swap. Read-out then streams one beat per cycle on out_valid, and
// a new beat is taken at the earliest in the cycle after the last result beat.
// The receiver cannot stall: each result beat is on the ports for exactly one
// cycle. busy rises once the closing beat is taken and stays high through the
// last result beat.
// Depends on bse_pkg, bse_mem and bse_seq.
`default_nettype none

module bubble_sort_engine
  import bse_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_final_res
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  bse_seq #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_value    (in_value),
    .in_last     (in_last),
    .busy        (busy),
    .out_valid_r (out_valid),
    .out_final_r (out_final_res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  bse_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .re        (mem_re),
    .raddr     (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // Read data register feeds the result port directly.
  assign out_sorted_value = mem_rdata;

endmodule : bubble_sort_engine

`default_nettype wire

// ----- src/bse_checker.sv -----
// Port-level checks for the bubble sort engine, bound to the top level.
// No package dependencies; sees the top-level handshake ports only.
`default_nettype none

module bse_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_final_res
);

  logic in_acc;
  assign in_acc = start && !busy;

  // Results only appear while a set is in flight.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while not busy");

  // A closing beat starts the sort.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> busy)
    else $error("closing beat did not raise busy");

  // Plain load beats keep the engine ready.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last |=> !busy && !out_valid)
    else $error("load beat disturbed the engine");

  // Result beats run back to back until the final one.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> out_valid)
    else $error("gap inside result burst");

  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid && !busy)
    else $error("activity after final result beat");

endmodule : bse_checker

bind bubble_sort_engine bse_checker u_bse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_final_res (out_final_res)
);

`default_nettype wire
